// File: design/ggps_pkg.sv
// ggps_pkg: shared widths, register indexes and the store request struct
// for the grid gradient power stream unit; no dependencies
package ggps_pkg;

	localparam int MAX_EDGE    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int WIN_DEPTH   = 2 * MAX_EDGE * MAX_EDGE + 1;
	localparam int DLY_DEPTH   = MAX_EDGE * MAX_EDGE + 1;
	localparam int WIN_AW      = $clog2(WIN_DEPTH);
	localparam int DLY_AW      = $clog2(DLY_DEPTH);
	localparam int EDGE_W      = 5;
	localparam int NN_W        = $clog2(MAX_EDGE * MAX_EDGE + 1);
	localparam int TOT_W       = $clog2(MAX_EDGE * MAX_EDGE * MAX_EDGE + 1);
	localparam int CNT_W       = 12;
	localparam int CFG_W       = 25;
	localparam int MIN_EDGE    = 3;

	localparam logic [1:0] CFG_GRID_EDGE   = 2'd0;
	localparam logic [1:0] CFG_HALF_INV_SP = 2'd1;
	localparam logic [1:0] CFG_VOLUME_ELEM = 2'd2;

	typedef struct packed {
		logic              wr;       // write the accepted voxel
		logic              restart;  // pointers back to zero, after this write if there is one
		logic              rd;       // read both stores
		logic [WIN_AW-1:0] win_off;  // distance back from the last written voxel
		logic [DLY_AW-1:0] dly_off;
	} ggps_store_req_t;

endpackage

// File: design/grid_gradient_power_stream_unit.sv
// grid_gradient_power_stream_unit: top level, sequencer and arithmetic
// depends on ggps_pkg and ggps_store
//
// Voxels of an n*n*n grid enter on the s_ channel in raster order, x fastest:
// s_tdata holds the potential sample and the weight sample. Once one plane has
// been taken in, each voxel request yields one result on the m_ channel for the
// voxel one plane earlier: index, three scaled gradients and the running power
// total; m_tlast marks the last result of a frame. The last plane is not emitted.
// Registers are written on the cfg_ port; writing the edge restarts the frame.
// Filling-phase voxels are only stored. A boundary voxel goes from the accept
// step straight to the output step; an interior voxel passes the accept step,
// three gradients of 5 steps each through the single read port of the potential
// window and one multiplier, 6 steps of the power term and the output step.
// The result sits in an output register, so the next voxel is taken while it
// waits; a stalled receiver holds the following result back in its last step.
// Reset clears the counter, the total and the pointers and loads the register
// defaults; store contents are not cleared and need not be.
module grid_gradient_power_stream_unit
	import ggps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // potential_sample[15:0], weight_sample[31:16]
	output logic               m_tvalid,
	input  logic               m_tready,
	// voxel_number[11:0], gradient_x[43:12], gradient_y[75:44], gradient_z[107:76],
	// power_total[171:108], zero fill
	output logic [175:0]       m_tdata,
	output logic               m_tlast,   // final_result
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_DIFF, S_MUL, S_RND,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_OUT
	} state_t;

	state_t state_q;

	logic [EDGE_W-1:0] edge_q;
	logic [CFG_W-1:0]  his_q, vol_q;
	logic [CNT_W-1:0]  cnt_q, vnum_q;
	logic [EDGE_W-1:0] vx_q, vy_q, vz_q;
	logic signed [63:0] acc_q, term_q;
	logic               last_q;
	logic [1:0]         ax_q;
	logic signed [SAMPLE_BITS-1:0] pin_q, a_q, w_q;
	logic signed [SAMPLE_BITS:0]   diff_q;
	logic signed [42:0] prod_q;
	logic signed [31:0] gx_q, gy_q, gz_q;
	logic signed [33:0] gsum_q;
	logic signed [49:0] wprod_q;
	logic               neg_q;
	logic [48:0]        mag_q;
	logic [49:0]        plo_q;
	logic [48:0]        phi_q;

	logic [EDGE_W-1:0] n;
	logic [NN_W-1:0]   nn;
	logic [TOT_W-1:0]  total;
	logic              accept, emit, last, interior;
	logic signed [SAMPLE_BITS-1:0] pot_rd, wgt_rd;
	ggps_store_req_t   sreq;
	logic signed [43:0] rnd;
	logic signed [31:0] grad;
	logic [74:0]        full;
	logic [63:0]        lim, rmag;
	logic signed [64:0] sum;
	logic signed [63:0] acc_new;
	logic               load_out;

	always_comb begin
		if (edge_q < EDGE_W'(MIN_EDGE)) begin
			n = EDGE_W'(MIN_EDGE);
		end else if (edge_q > EDGE_W'(MAX_EDGE)) begin
			n = EDGE_W'(MAX_EDGE);
		end else begin
			n = edge_q;
		end
		nn    = NN_W'(NN_W'(n) * NN_W'(n));
		total = TOT_W'(TOT_W'(nn) * TOT_W'(n));
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign emit     = cnt_q >= CNT_W'(nn);
	assign last     = (TOT_W'(cnt_q) + 1'b1) == total;
	assign interior = vx_q >= 1 && vx_q <= n - 2 && vy_q >= 1 && vy_q <= n - 2
		&& vz_q >= 1 && vz_q <= n - 2;

	// store requests from the sequencer
	always_comb begin
		sreq.wr      = accept;
		sreq.restart = (accept && last) || (cfg_we && cfg_index == CFG_GRID_EDGE);
		sreq.rd      = (state_q == S_RDA) || (state_q == S_RDB);
		sreq.dly_off = DLY_AW'(nn);
		sreq.win_off = '0;
		case ({state_q == S_RDB, ax_q})
			3'b000:  sreq.win_off = WIN_AW'(nn - 1'b1);
			3'b100:  sreq.win_off = WIN_AW'(nn + 1'b1);
			3'b001:  sreq.win_off = WIN_AW'(nn - NN_W'(n));
			3'b101:  sreq.win_off = WIN_AW'(nn + NN_W'(n));
			3'b110:  sreq.win_off = WIN_AW'({nn, 1'b0});
			default: sreq.win_off = '0;
		endcase
	end

	ggps_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.wr_pot (s_tdata[15:0]),
		.wr_wgt (s_tdata[31:16]),
		.pot_rd (pot_rd),
		.wgt_rd (wgt_rd)
	);

	always_comb begin
		rnd = 44'(prod_q) + 44'sd2048;
		rnd = rnd >>> 12;
		if (rnd > 44'sh0007FFFFFFF) begin
			grad = 32'sh7FFFFFFF;
		end else if (rnd < -44'sh00080000000) begin
			grad = -32'sh80000000;
		end else begin
			grad = rnd[31:0];
		end
		full = 75'(plo_q) + {1'b0, phi_q, 25'd0};
		lim  = neg_q ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
		rmag = (full > 75'(lim)) ? lim : full[63:0];
		sum  = 65'(acc_q) + 65'(term_q);
		if (sum[64] != sum[63]) begin
			acc_new = sum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
		end else begin
			acc_new = sum[63:0];
		end
	end

	assign load_out = (state_q == S_OUT) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			edge_q   <= EDGE_W'(10);
			his_q    <= CFG_W'(32768);
			vol_q    <= CFG_W'(65536);
			cnt_q    <= '0;
			vx_q     <= '0;
			vy_q     <= '0;
			vz_q     <= '0;
			acc_q    <= '0;
			ax_q     <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pin_q  <= s_tdata[15:0];
						cnt_q  <= last ? '0 : cnt_q + 1'b1;
						last_q <= last;
						vnum_q <= cnt_q - CNT_W'(nn);
						ax_q   <= '0;
						if (emit) begin
							if (last) begin
								vx_q <= '0;
								vy_q <= '0;
								vz_q <= '0;
							end else if (vx_q == n - 1'b1) begin
								vx_q <= '0;
								if (vy_q == n - 1'b1) begin
									vy_q <= '0;
									vz_q <= vz_q + 1'b1;
								end else begin
									vy_q <= vy_q + 1'b1;
								end
							end else begin
								vx_q <= vx_q + 1'b1;
							end
							if (interior) begin
								state_q <= S_RDA;
							end else begin
								gx_q    <= '0;
								gy_q    <= '0;
								gz_q    <= '0;
								term_q  <= '0;
								state_q <= S_OUT;
							end
						end
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					a_q <= (ax_q == 2'd2) ? pin_q : pot_rd;
					if (ax_q == 2'd0) begin
						w_q <= wgt_rd;
					end
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					diff_q  <= (SAMPLE_BITS+1)'(a_q) - (SAMPLE_BITS+1)'(pot_rd);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= 43'(diff_q) * $signed({18'd0, his_q});
					state_q <= S_RND;
				end
				S_RND: begin
					case (ax_q)
						2'd0:    gx_q <= grad;
						2'd1:    gy_q <= grad;
						default: gz_q <= grad;
					endcase
					if (ax_q == 2'd2) begin
						state_q <= S_P0;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_RDA;
					end
				end
				S_P0: begin
					gsum_q  <= 34'(gx_q) + 34'(gy_q) + 34'(gz_q);
					state_q <= S_P1;
				end
				S_P1: begin
					wprod_q <= 50'(w_q) * 50'(gsum_q);
					state_q <= S_P2;
				end
				S_P2: begin
					neg_q   <= wprod_q[49];
					mag_q   <= wprod_q[49] ? 49'(-wprod_q) : wprod_q[48:0];
					state_q <= S_P3;
				end
				S_P3: begin
					plo_q   <= 50'(mag_q[24:0]) * 50'(vol_q);
					state_q <= S_P4;
				end
				S_P4: begin
					phi_q   <= 49'(mag_q[48:25]) * 49'(vol_q);
					state_q <= S_P5;
				end
				S_P5: begin
					term_q  <= neg_q ? -$signed(rmag) : $signed(rmag);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						acc_q    <= last_q ? '0 : acc_new;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_EDGE: begin
						edge_q <= cfg_data[EDGE_W-1:0];
						cnt_q  <= '0;
						acc_q  <= '0;
						vx_q   <= '0;
						vy_q   <= '0;
						vz_q   <= '0;
					end
					CFG_HALF_INV_SP: his_q <= cfg_data;
					CFG_VOLUME_ELEM: vol_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {4'd0, acc_new, gz_q, gy_q, gx_q, vnum_q};
			m_tlast <= last_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) TOT_W'(cnt_q) < total)
		else $error("voxel counter beyond frame");
	assert property (@(posedge clk) disable iff (!arst_n) load_out |=> m_tvalid)
		else $error("result lost at load");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> !s_tready)
		else $error("new request taken while a result is in work");

endmodule

// File: design/ggps_store.sv
// ggps_store: potential window and weight delay memories with ring pointers
// depends on ggps_pkg
module ggps_store
	import ggps_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  ggps_store_req_t               req,
	input  logic signed [SAMPLE_BITS-1:0] wr_pot,
	input  logic signed [SAMPLE_BITS-1:0] wr_wgt,
	output logic signed [SAMPLE_BITS-1:0] pot_rd,
	output logic signed [SAMPLE_BITS-1:0] wgt_rd
);

	logic signed [SAMPLE_BITS-1:0] win_mem [WIN_DEPTH];
	logic signed [SAMPLE_BITS-1:0] dly_mem [DLY_DEPTH];

	logic [WIN_AW-1:0] wptr_q, wbase_q, win_addr;
	logic [DLY_AW-1:0] dptr_q, dbase_q, dly_addr;
	logic [WIN_AW:0]   win_diff;
	logic [DLY_AW:0]   dly_diff;

	// address of the entry off places before the last written one, mod depth
	always_comb begin
		win_diff = {1'b0, wbase_q} - {1'b0, req.win_off};
		if (win_diff[WIN_AW]) begin
			win_addr = WIN_AW'(win_diff + (WIN_AW+1)'(WIN_DEPTH));
		end else begin
			win_addr = win_diff[WIN_AW-1:0];
		end
		dly_diff = {1'b0, dbase_q} - {1'b0, req.dly_off};
		if (dly_diff[DLY_AW]) begin
			dly_addr = DLY_AW'(dly_diff + (DLY_AW+1)'(DLY_DEPTH));
		end else begin
			dly_addr = dly_diff[DLY_AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			dptr_q  <= '0;
			wbase_q <= '0;
			dbase_q <= '0;
		end else if (req.wr) begin
			wbase_q <= wptr_q;
			dbase_q <= dptr_q;
			if (req.restart || wptr_q == WIN_AW'(WIN_DEPTH - 1)) begin
				wptr_q <= '0;
			end else begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (req.restart || dptr_q == DLY_AW'(DLY_DEPTH - 1)) begin
				dptr_q <= '0;
			end else begin
				dptr_q <= dptr_q + 1'b1;
			end
		end else if (req.restart) begin
			wptr_q <= '0;
			dptr_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			win_mem[wptr_q] <= wr_pot;
			dly_mem[dptr_q] <= wr_wgt;
		end
		if (req.rd) begin
			pot_rd <= win_mem[win_addr];
			wgt_rd <= dly_mem[dly_addr];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wptr_q < WIN_AW'(WIN_DEPTH))
		else $error("window pointer out of range");
	assert property (@(posedge clk) disable iff (!arst_n) dptr_q < DLY_AW'(DLY_DEPTH))
		else $error("delay pointer out of range");
	assert property (@(posedge clk) disable iff (!arst_n) req.rd |-> !req.wr)
		else $error("store read and write in the same cycle");

endmodule
